// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk_i, masked while rst_ni is low.
`define PJD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Check that a condition never holds on a rising edge of clk_i.
`define PJD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define PJD_ASSERT(lbl, prop, msg)
`define PJD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/pjd_pkg.sv =====
// Types and constants of the priority job dispatcher.
package pjd_pkg;

  localparam int NUM_WORKERS = 4;
  localparam int WIDX_W      = 2;
  localparam int TYPE_BITS   = 8;
  localparam int TAG_W       = 16;
  localparam int NID_W       = 16;
  localparam int WCNT_W      = 3;
  localparam int NUM_QUEUES  = 3;
  localparam int QIDX_W      = 2;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 3;

  // Queue numbering inside the queue memory
  localparam logic [QIDX_W-1:0] Q_HIGH   = 2'd0;
  localparam logic [QIDX_W-1:0] Q_NORMAL = 2'd1;
  localparam logic [QIDX_W-1:0] Q_LOW    = 2'd2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WORKER_COUNT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_MASK_W0   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TYPE_MASK_LAST = 3'd4;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_DONE   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PRIO_NONE   = 2'd0,
    PRIO_LOW    = 2'd1,
    PRIO_NORMAL = 2'd2,
    PRIO_HIGH   = 2'd3
  } prio_e;

  typedef enum logic [2:0] {
    KIND_ASSIGNED = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_REJECTED = 3'd2,
    KIND_DROPPED  = 3'd3,
    KIND_NOTICE   = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_MATCH = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  typedef struct packed {
    logic [TYPE_BITS-1:0] jtype;
    logic [TAG_W-1:0]     tag;
  } entry_t;

  typedef struct packed {
    kind_e             kind;
    logic [WIDX_W-1:0] widx;
    logic [TAG_W-1:0]  tag;
    logic              outcome;
    logic [NID_W-1:0]  nid;
  } result_t;

  typedef struct packed {
    logic              assign_v;
    logic [WIDX_W-1:0] assign_idx;
    logic [TAG_W-1:0]  assign_tag;
    logic              release_v;
    logic [WIDX_W-1:0] release_idx;
  } pool_req_t;

  typedef struct packed {
    logic              found;
    logic [WIDX_W-1:0] found_idx;
    logic              sel_busy;
    logic [TAG_W-1:0]  sel_job;
  } pool_rsp_t;

endpackage

// ===== hdl/pjd_qmem.sv =====
// Shared job queue memory: one write port, one registered read port.
module pjd_qmem
  import pjd_pkg::*;
#(
  parameter int PTR_W = 9
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [PTR_W+1:0]   waddr_i,
  input  entry_t             wdata_i,
  input  logic               re_i,
  input  logic [PTR_W+1:0]   raddr_i,
  output entry_t             rdata_o
);

  localparam int ENTRIES = NUM_QUEUES << PTR_W;

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pjd_worker_pool.sv =====
// Worker busy flags, running job tags and the type-mask worker finder.
`include "assert_macros.svh"

module pjd_worker_pool
  import pjd_pkg::*;
(
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [WCNT_W-1:0]                    worker_count_i,
  input  logic [NUM_WORKERS-1:0][TYPE_BITS-1:0] type_mask_i,
  input  logic [TYPE_BITS-1:0]                 match_type_i,
  input  logic [WIDX_W-1:0]                    sel_idx_i,
  input  pool_req_t                            req_i,
  output pool_rsp_t                            rsp_o
);

  logic [NUM_WORKERS-1:0] busy_q;
  logic [TAG_W-1:0]       job_q [NUM_WORKERS];
  logic [WCNT_W-1:0]      n_en;
  logic [NUM_WORKERS-1:0] hit;

  // Clamp the enabled count to the number of workers built.
  assign n_en = (worker_count_i > WCNT_W'(NUM_WORKERS)) ? WCNT_W'(NUM_WORKERS)
                                                         : worker_count_i;

  always_comb begin
    rsp_o.found     = 1'b0;
    rsp_o.found_idx = '0;
    for (int i = 0; i < NUM_WORKERS; i++) begin
      hit[i] = (WCNT_W'(i) < n_en) && !busy_q[i] &&
               ((type_mask_i[i] & match_type_i) != '0);
    end
    // Scan downward so the lowest matching worker wins.
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        rsp_o.found     = 1'b1;
        rsp_o.found_idx = WIDX_W'(i);
      end
    end
    rsp_o.sel_busy = busy_q[sel_idx_i];
    rsp_o.sel_job  = job_q[sel_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      if (req_i.assign_v) begin
        busy_q[req_i.assign_idx] <= 1'b1;
      end
      if (req_i.release_v) begin
        busy_q[req_i.release_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.assign_v) begin
      job_q[req_i.assign_idx] <= req_i.assign_tag;
    end
  end

  `PJD_ASSERT(a_assign_free, req_i.assign_v |-> !busy_q[req_i.assign_idx], "job given to busy worker")
  `PJD_ASSERT(a_release_busy, req_i.release_v |-> busy_q[req_i.release_idx], "free worker released")
  `PJD_ASSERT(a_assign_marks, req_i.assign_v |=> busy_q[$past(req_i.assign_idx)], "assigned worker not busy")
  `PJD_ASSERT_NEVER(a_one_op, req_i.assign_v && req_i.release_v, "assign and release together")

endmodule

// ===== hdl/priority_job_dispatcher.sv =====
// Priority job dispatcher top level: stream ports, APB registers and the dispatch sequencer.
//
// The dispatcher takes one command beat at a time (submit, dispatch tick or job done) and
// returns zero to four result beats, the final one marked by tlast. The three priority
// queues (high, normal, low) share one memory of 3 * 2^ceil(log2(QUEUE_DEPTH)) entries
// with a registered read; the heads, fill counts, worker busy flags and the
// notice counter sit in flip-flops and reset at once, so no clearing pass runs after
// reset and queue entries that were never written are never read. A submit or a done
// passes through accept, execute and flush before the next command beat is accepted.
// A dispatch tick runs accept and execute, then serves the high, normal and low queues
// in turn over the single read port: an empty queue is skipped; otherwise its head is
// read and matched against the worker masks, which assigns it and reads the next head
// or, with no free matching worker, moves on; a flush ends the tick. A new command beat
// is taken as soon as the sequencer is idle, even while the last result still waits in
// the output register; result emission stalls only when that register is full and not
// being drained. Configuration is written through the APB port; the user must write it
// only while the block is idle, which the block does not enforce. Register 0 is
// worker_count, registers 1 to 4 are the type masks of workers 0 to 3.
module priority_job_dispatcher
  import pjd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // job_tag[15:0], job_type[23:16], priority_req[25:24], worker[27:26],
  // succeeded[28], wants_notice[29], zero[31:30]
  input  logic [31:0]       s_axis_tdata,
  // command[1:0]
  input  logic [1:0]        s_axis_tuser,
  // result channel
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // worker_index[1:0], out_tag[17:2], outcome[18], notice_id[34:19], zero[39:35]
  output logic [39:0]       m_axis_tdata,
  // kind[2:0]
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

  // ---------------- configuration registers ----------------
  logic [WCNT_W-1:0]                     worker_count_q;
  logic [NUM_WORKERS-1:0][TYPE_BITS-1:0] type_mask_q;
  logic [REG_IDX_W-1:0]                  reg_idx;
  logic [WIDX_W-1:0]                     mask_idx;
  logic                                  cfg_we;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[APB_AW-1:2];
  assign mask_idx = WIDX_W'(reg_idx - REG_TYPE_MASK_W0);
  assign cfg_we   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WCNT_W'(1);
      type_mask_q    <= '1;
    end else if (cfg_we) begin
      case (reg_idx) inside
        REG_WORKER_COUNT: worker_count_q <= pwdata[WCNT_W-1:0];
        [REG_TYPE_MASK_W0:REG_TYPE_MASK_LAST]: type_mask_q[mask_idx] <= pwdata[TYPE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx) inside
      REG_WORKER_COUNT: prdata = APB_DW'(worker_count_q);
      [REG_TYPE_MASK_W0:REG_TYPE_MASK_LAST]: prdata = APB_DW'(type_mask_q[mask_idx]);
      default: prdata = '0;
    endcase
  end

  // ---------------- command capture ----------------
  state_e               state_q, state_d;
  logic                 in_fire;
  cmd_e                 cmd_q;
  logic [TAG_W-1:0]     tag_q;
  logic [TYPE_BITS-1:0] type_q;
  prio_e                prio_q;
  logic [WIDX_W-1:0]    wk_q;
  logic                 ok_q;
  logic                 want_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Hold the accepted beat for the whole command.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_e'(s_axis_tuser);
      tag_q  <= s_axis_tdata[15:0];
      type_q <= s_axis_tdata[23:16];
      prio_q <= prio_e'(s_axis_tdata[25:24]);
      wk_q   <= s_axis_tdata[27:26];
      ok_q   <= s_axis_tdata[28];
      want_q <= s_axis_tdata[29];
    end
  end

  // ---------------- queue pointers ----------------
  logic [PTR_W-1:0]  head_q  [NUM_QUEUES];
  logic [PTR_W-1:0]  head_d  [NUM_QUEUES];
  logic [CNT_W-1:0]  count_q [NUM_QUEUES];
  logic [CNT_W-1:0]  count_d [NUM_QUEUES];
  logic [QIDX_W-1:0] q_q, q_d;
  logic [QIDX_W-1:0] enq_idx;
  logic [QIDX_W-1:0] qsel;
  logic [PTR_W-1:0]  head_sel;
  logic [CNT_W-1:0]  count_sel;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_pos;
  logic [PTR_W-1:0]  head_next;

  always_comb begin
    case (prio_q)
      PRIO_HIGH:   enq_idx = Q_HIGH;
      PRIO_NORMAL: enq_idx = Q_NORMAL;
      default:     enq_idx = Q_LOW;
    endcase
  end

  // One queue is looked at per cycle: the submit target or the queue under dispatch.
  assign qsel      = (state_q == ST_EXEC) ? enq_idx : q_q;
  assign head_sel  = head_q[qsel];
  assign count_sel = count_q[qsel];
  assign tail_sum  = SUM_W'(head_sel) + SUM_W'(count_sel);
  assign tail_pos  = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                             : PTR_W'(tail_sum);
  assign head_next = (head_sel == PTR_LAST) ? '0 : head_sel + PTR_W'(1);

  // ---------------- queue memory ----------------
  logic   mem_we, mem_re;
  entry_t mem_wdata, rd_entry;

  assign mem_wdata.jtype = type_q;
  assign mem_wdata.tag   = tag_q;

  pjd_qmem #(
    .PTR_W (PTR_W)
  ) u_qmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({qsel, tail_pos}),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i ({qsel, head_sel}),
    .rdata_o (rd_entry)
  );

  // ---------------- worker pool ----------------
  pool_req_t            pool_req;
  pool_rsp_t            pool_rsp;
  logic [TYPE_BITS-1:0] match_type;

  // Match the queue head in the match cycle, the submitted job otherwise.
  assign match_type = (state_q == ST_MATCH) ? rd_entry.jtype : type_q;

  pjd_worker_pool u_pool (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .worker_count_i (worker_count_q),
    .type_mask_i    (type_mask_q),
    .match_type_i   (match_type),
    .sel_idx_i      (wk_q),
    .req_i          (pool_req),
    .rsp_o          (pool_rsp)
  );

  // ---------------- sequencer ----------------
  logic [NID_W-1:0] notice_q, notice_d;
  result_t          pend_q, pend_d;
  logic             pend_v_q, pend_v_d;
  result_t          out_q;
  logic             out_last_q, out_v_q;
  logic             out_free;
  logic             push, push_last;

  assign out_free = !out_v_q || m_axis_tready;

  // A dispatch result is held in the pending slot until the next step shows
  // whether another result follows, so tlast can be set on the final one.
  always_comb begin
    state_d   = state_q;
    q_d       = q_q;
    head_d    = head_q;
    count_d   = count_q;
    notice_d  = notice_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    push      = 1'b0;
    push_last = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    pool_req  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d        = ST_FLUSH;
        pend_d.widx    = '0;
        pend_d.tag     = tag_q;
        pend_d.outcome = 1'b0;
        pend_d.nid     = '0;
        case (cmd_q)
          CMD_SUBMIT: begin
            pend_v_d = 1'b1;
            if (prio_q == PRIO_NONE) begin
              pend_d.kind = KIND_REJECTED;
            end else if (prio_q == PRIO_HIGH && pool_rsp.found) begin
              pend_d.kind         = KIND_ASSIGNED;
              pend_d.widx         = pool_rsp.found_idx;
              pool_req.assign_v   = 1'b1;
              pool_req.assign_idx = pool_rsp.found_idx;
              pool_req.assign_tag = tag_q;
            end else if (count_sel != CNT_FULL) begin
              pend_d.kind    = KIND_QUEUED;
              mem_we         = 1'b1;
              count_d[qsel]  = count_sel + CNT_W'(1);
            end else begin
              pend_d.kind = KIND_DROPPED;
            end
          end
          CMD_TICK: begin
            q_d     = Q_HIGH;
            state_d = ST_READ;
          end
          CMD_DONE: begin
            if (pool_rsp.sel_busy) begin
              pool_req.release_v   = 1'b1;
              pool_req.release_idx = wk_q;
              if (want_q) begin
                pend_v_d       = 1'b1;
                pend_d.kind    = KIND_NOTICE;
                pend_d.widx    = wk_q;
                pend_d.tag     = pool_rsp.sel_job;
                pend_d.outcome = ok_q;
                pend_d.nid     = notice_q;
                notice_d       = notice_q + NID_W'(1);
              end
            end
          end
          default: ;
        endcase
      end

      ST_READ: begin
        if (count_sel == '0) begin
          // Empty queue: advance to the next one or finish.
          if (q_q == Q_LOW) begin
            state_d = ST_FLUSH;
          end else begin
            q_d = q_q + QIDX_W'(1);
          end
        end else begin
          mem_re  = 1'b1;
          state_d = ST_MATCH;
        end
      end

      ST_MATCH: begin
        if (!pool_rsp.found) begin
          // Head blocks this queue.
          if (q_q == Q_LOW) begin
            state_d = ST_FLUSH;
          end else begin
            q_d     = q_q + QIDX_W'(1);
            state_d = ST_READ;
          end
        end else if (!pend_v_q || out_free) begin
          push                = pend_v_q;
          pend_v_d            = 1'b1;
          pend_d.kind         = KIND_ASSIGNED;
          pend_d.widx         = pool_rsp.found_idx;
          pend_d.tag          = rd_entry.tag;
          pend_d.outcome      = 1'b0;
          pend_d.nid          = '0;
          pool_req.assign_v   = 1'b1;
          pool_req.assign_idx = pool_rsp.found_idx;
          pool_req.assign_tag = rd_entry.tag;
          head_d[q_q]         = head_next;
          count_d[q_q]        = count_sel - CNT_W'(1);
          state_d             = ST_READ;
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      q_q      <= Q_HIGH;
      notice_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      q_q      <= q_d;
      notice_q <= notice_d;
      pend_v_q <= pend_v_d;
      head_q   <= head_d;
      count_q  <= count_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  // ---------------- result channel ----------------
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'b0, out_q.nid, out_q.outcome, out_q.tag, out_q.widx};

  `PJD_ASSERT(a_push_room, push |-> out_free, "result beat overwrites a waiting beat")
  `PJD_ASSERT(a_read_nonempty, mem_re |-> (count_sel != '0), "read from an empty queue")
  `PJD_ASSERT(a_write_room, mem_we |-> (count_sel != CNT_FULL), "write into a full queue")

endmodule

// ===== sim/tb_priority_job_dispatcher.sv =====
// Self-checking testbench for the priority job dispatcher: stream beats against a built-in predictor.
module tb_priority_job_dispatcher;
  import pjd_pkg::*;

  localparam int QDEPTH        = 512;
  localparam int MAX_ASSIGN    = 4;     // assignments per dispatch tick
  localparam int SETTLE_CYCLES = 40;    // lets the longest tick run out after the owed beats
  localparam int CYCLE_LIMIT   = 1200000;
  localparam int PHASE_ITEMS   = 95;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [1:0]           CMD_RESERVED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = REG_TYPE_MASK_LAST + 3'd1;

  typedef struct packed {
    kind_e             kind;
    logic [WIDX_W-1:0] widx;
    logic [TAG_W-1:0]  tag;
    logic              outcome;
    logic [NID_W-1:0]  nid;
    logic              last;
  } result_beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [39:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  priority_job_dispatcher #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Dispatcher state as the block should hold it; updated at each accepted command beat.
  entry_t               fifo_mem [NUM_QUEUES][QDEPTH];
  int                   head_ptr [NUM_QUEUES] = '{default: 0};
  int                   fill     [NUM_QUEUES] = '{default: 0};
  bit                   busy     [NUM_WORKERS] = '{default: 1'b0};
  logic [TAG_W-1:0]     job_of   [NUM_WORKERS] = '{default: '0};
  logic [NID_W-1:0]     notice_seq = '0;
  logic [WCNT_W-1:0]    worker_cnt = 3'd1;
  logic [TYPE_BITS-1:0] type_mask [NUM_WORKERS] = '{default: 8'hFF};

  result_beat_t due_results[$];   // result beats still owed by the block, oldest first

  int errors      = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Lowest enabled, free worker whose mask shares a bit with the job type.
  function automatic int free_match(logic [TYPE_BITS-1:0] jtype);
    int lim;
    int i;
    lim = (worker_cnt > NUM_WORKERS) ? NUM_WORKERS : int'(worker_cnt);
    for (i = 0; i < lim; i++)
      if ((type_mask[i] & jtype) != '0 && !busy[i]) return i;
    return -1;
  endfunction

  function automatic int pick_busy();
    int cand[$];
    int i;
    for (i = 0; i < NUM_WORKERS; i++)
      if (busy[i]) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic void add_result(kind_e k, logic [WIDX_W-1:0] w, logic [TAG_W-1:0] tag,
                                     logic oc, logic [NID_W-1:0] nid);
    result_beat_t b;
    b.kind = k;
    b.widx = w;
    b.tag = tag;
    b.outcome = oc;
    b.nid = nid;
    b.last = 1'b0;
    due_results.push_back(b);
  endfunction

  // Advance the dispatcher state by one command and queue the result beats it owes.
  function automatic void apply_command(logic [1:0] cmd, logic [TAG_W-1:0] tag,
                                        logic [TYPE_BITS-1:0] jtype, logic [1:0] prio,
                                        logic [WIDX_W-1:0] wk, logic ok, logic want);
    int     n;
    int     w;
    int     q;
    entry_t head;
    n = 0;
    case (cmd)
      CMD_SUBMIT: begin
        w = (prio == PRIO_HIGH) ? free_match(jtype) : -1;
        q = (prio == PRIO_HIGH) ? Q_HIGH : (prio == PRIO_NORMAL) ? Q_NORMAL : Q_LOW;
        if (prio == PRIO_NONE) begin
          add_result(KIND_REJECTED, '0, tag, 1'b0, '0);
        end else if (w >= 0) begin
          busy[w] = 1'b1;
          job_of[w] = tag;
          add_result(KIND_ASSIGNED, w[WIDX_W-1:0], tag, 1'b0, '0);
        end else if (fill[q] < QDEPTH) begin
          head.jtype = jtype;
          head.tag = tag;
          fifo_mem[q][(head_ptr[q] + fill[q]) % QDEPTH] = head;
          fill[q]++;
          add_result(KIND_QUEUED, '0, tag, 1'b0, '0);
        end else begin
          add_result(KIND_DROPPED, '0, tag, 1'b0, '0);
        end
        n = 1;
      end
      CMD_TICK: begin
        // Serve high, normal, low; stop a queue as soon as its head finds no worker.
        for (q = 0; q < NUM_QUEUES; q++)
          while (fill[q] > 0 && n < MAX_ASSIGN) begin
            head = fifo_mem[q][head_ptr[q]];
            w = free_match(head.jtype);
            if (w < 0) break;
            busy[w] = 1'b1;
            job_of[w] = head.tag;
            head_ptr[q] = (head_ptr[q] + 1) % QDEPTH;
            fill[q]--;
            add_result(KIND_ASSIGNED, w[WIDX_W-1:0], head.tag, 1'b0, '0);
            n++;
          end
      end
      CMD_DONE: begin
        if (busy[wk]) begin
          busy[wk] = 1'b0;
          if (want) begin
            add_result(KIND_NOTICE, wk, job_of[wk], ok, notice_seq);
            notice_seq++;
            n = 1;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
  endfunction

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  // Offer one command beat from the falling edge, hold it until accepted, then maybe idle.
  task automatic send_beat(logic [1:0] cmd, logic [TAG_W-1:0] tag, logic [TYPE_BITS-1:0] jtype,
                           logic [1:0] prio, logic [WIDX_W-1:0] wk, logic ok, logic want);
    int g;
    s_axis_tdata  <= {2'b00, want, ok, wk, prio, jtype, tag};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(cmd, tag, jtype, prio, wk, ok, want);
    @(negedge clk_i);
    g = tx_idle_en ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  task automatic submit(logic [TAG_W-1:0] tag, logic [TYPE_BITS-1:0] jtype, prio_e prio);
    send_beat(CMD_SUBMIT, tag, jtype, prio, 2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic tick();
    send_beat(CMD_TICK, 16'($urandom), 8'($urandom), 2'($urandom), 2'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  task automatic done(int wk, logic ok, logic want);
    send_beat(CMD_DONE, 16'($urandom), 8'($urandom), 2'($urandom), wk[WIDX_W-1:0], ok, want);
  endtask

  task automatic send_reserved();
    send_beat(CMD_RESERVED, 16'($urandom), 8'($urandom), 2'($urandom), 2'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // Drop valid, wait for every owed beat, then let a tick that assigns nothing run out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic read_reg(int idx);
    logic [31:0] want_val;
    want_val = (idx == REG_WORKER_COUNT) ? 32'(worker_cnt)
                                         : 32'(type_mask[idx - REG_TYPE_MASK_W0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_AW'(idx * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("prdata", want_val, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write one register, mirror it in the predictor, and read it back where it exists.
  task automatic write_reg(int idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_WORKER_COUNT) worker_cnt = value[WCNT_W-1:0];
    else if (idx <= REG_TYPE_MASK_LAST) type_mask[idx - REG_TYPE_MASK_W0] = value[TYPE_BITS-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    if (idx <= REG_TYPE_MASK_LAST) read_reg(idx);
  endtask

  // One random command; effective is low when the block will simply ignore it.
  task automatic send_random_item(output bit effective);
    int r;
    int w;
    r = $urandom_range(0, 99);
    effective = 1'b1;
    if (r < 42) begin
      if ($urandom_range(0, 9) == 0)
        submit(16'($urandom), 8'($urandom), PRIO_NONE);
      else
        submit(16'($urandom), 8'($urandom_range(1, 255)), prio_e'($urandom_range(1, 3)));
    end else if (r < 70) begin
      tick();
    end else if (r < 97) begin
      w = pick_busy();
      if (w < 0 || $urandom_range(0, 4) == 0) begin
        w = $urandom_range(0, NUM_WORKERS - 1);
        effective = busy[w];
      end
      done(w, 1'($urandom), 1'($urandom));
    end else begin
      effective = 1'b0;
      send_reserved();
    end
  endtask

  task automatic test_reset_values();
    int i;
    for (i = REG_WORKER_COUNT; i <= REG_TYPE_MASK_LAST; i++) read_reg(i);
  endtask

  // Reset config: only worker 0 enabled, all masks open.
  task automatic test_submit_paths();
    submit(16'hFFFF, 8'h00, PRIO_NONE);
    submit(16'h0000, 8'hFF, PRIO_HIGH);
    submit(16'hA5A5, 8'h01, PRIO_HIGH);
    submit(16'h5A5A, 8'h80, PRIO_NORMAL);
    submit(16'h1234, 8'h3C, PRIO_LOW);
    send_reserved();
    tick();
    done(1, 1'b1, 1'b1);
    done(0, 1'b1, 1'b1);
    tick();
    done(0, 1'b0, 1'b0);
    tick();
    done(0, 1'b0, 1'b1);
    tick();
    done(0, 1'b1, 1'b1);
  endtask

  // No worker enabled, then a count above the pool; one tick hits the assignment cap.
  task automatic test_worker_limits();
    int i;
    settle();
    write_reg(REG_WORKER_COUNT, 0);
    for (i = 0; i < MAX_ASSIGN + 1; i++)
      submit(16'($urandom), 8'($urandom_range(1, 255)), PRIO_HIGH);
    tick();
    settle();
    write_reg(REG_WORKER_COUNT, 7);
    tick();
    tick();
    for (i = 0; i < NUM_WORKERS; i++) done(i, 1'($urandom), 1'b1);
    tick();
    done(0, 1'b1, 1'b1);
  endtask

  // A head whose type no worker takes holds back the matching job behind it.
  task automatic test_type_blocking();
    settle();
    write_reg(REG_WORKER_COUNT, 2);
    write_reg(REG_TYPE_MASK_W0, 8'h00);
    write_reg(REG_TYPE_MASK_W0 + 1, 8'h01);
    write_reg(REG_UNMAPPED, $urandom);
    submit(16'h8001, 8'h80, PRIO_NORMAL);
    submit(16'h8002, 8'h01, PRIO_NORMAL);
    tick();
    settle();
    write_reg(REG_TYPE_MASK_W0 + 1, 8'hFF);
    tick();
    done(1, 1'b1, 1'b1);
    tick();
    done(1, 1'b0, 1'b1);
  endtask

  // Fill the low queue to the brim, overflow it once, then drain it through the pool.
  task automatic test_full_queue();
    int i;
    int w;
    settle();
    write_reg(REG_WORKER_COUNT, NUM_WORKERS);
    for (i = 0; i < NUM_WORKERS; i++) write_reg(REG_TYPE_MASK_W0 + i, 8'hFF);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (fill[Q_LOW] < QDEPTH) submit(16'($urandom), 8'($urandom_range(1, 255)), PRIO_LOW);
    submit(16'($urandom), 8'($urandom_range(1, 255)), PRIO_LOW);
    while (fill[Q_HIGH] + fill[Q_NORMAL] + fill[Q_LOW] != 0) begin
      tick();
      w = pick_busy();
      while (w >= 0) begin
        done(w, 1'($urandom), 1'($urandom));
        w = pick_busy();
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Hold the result side off while beats keep coming, so the input must stall.
  task automatic test_backpressure();
    int i;
    bit eff;
    tx_idle_en = 1'b0;
    hold_left = HOLD_CYCLES;
    for (i = 0; i < 30; i++) send_random_item(eff);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_phases();
    int                   ph;
    int                   i;
    int                   cnt;
    int                   lim;
    int                   sent;
    bit                   eff;
    logic [TYPE_BITS-1:0] m [NUM_WORKERS];
    logic [TYPE_BITS-1:0] reach;
    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: cnt = NUM_WORKERS;
        1: cnt = 7;
        2: cnt = 1;
        default: cnt = $urandom_range(2, 3);
      endcase
      for (i = 0; i < NUM_WORKERS; i++) m[i] = (ph == 2) ? 8'h00 : 8'($urandom);
      // Open worker 0 to every type bit the other enabled workers miss, so no head
      // blocks for good.
      lim = (cnt > NUM_WORKERS) ? NUM_WORKERS : cnt;
      reach = '0;
      for (i = 1; i < lim; i++) reach |= m[i];
      m[0] |= ~reach;
      write_reg(REG_WORKER_COUNT, cnt);
      for (i = 0; i < NUM_WORKERS; i++) write_reg(REG_TYPE_MASK_W0 + i, m[i]);
      tx_idle_en = (ph != 1);
      rx_idle_en = (ph != 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_item(eff);
        sent += eff;
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Result-side ready: a long hold when asked, always ready with idling off, otherwise random stalls.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!rx_idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Compare each accepted result beat with the oldest owed one.
  always @(posedge clk_i) begin : result_check
    result_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual kind %0h tag %0h",
                 $time, m_axis_tuser, m_axis_tdata[17:2]);
      end else begin
        exp_beat = due_results.pop_front();
        check_field("kind", exp_beat.kind, m_axis_tuser);
        check_field("worker_index", exp_beat.widx, m_axis_tdata[1:0]);
        check_field("out_tag", exp_beat.tag, m_axis_tdata[17:2]);
        check_field("outcome", exp_beat.outcome, m_axis_tdata[18]);
        check_field("notice_id", exp_beat.nid, m_axis_tdata[34:19]);
        check_field("last", exp_beat.last, m_axis_tlast);
      end
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d result beats outstanding", $time, due_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_submit_paths();
    test_worker_limits();
    test_type_blocking();
    test_full_queue();
    test_backpressure();
    test_random_phases();
    settle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/pjd_pkg.sv
hdl/pjd_qmem.sv
hdl/pjd_worker_pool.sv
hdl/priority_job_dispatcher.sv
sim/tb_priority_job_dispatcher.sv
